// ===== src/dense_layer_forward_assert.svh =====
// assertion macros for the dense layer block
`ifndef DENSE_LAYER_FORWARD_ASSERT_SVH
`define DENSE_LAYER_FORWARD_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DLF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define DLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DLF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/dlf_pkg.sv =====
// shared constants, codes and command types of the dense layer block
`default_nettype none

package dlf_pkg;

  localparam int MAX_INPUTS_DEF  = 1024;
  localparam int MAX_OUTPUTS_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int ACC_WIDTH       = 48;
  localparam int FRAC_SHIFT      = 8;
  localparam int OP_WIDTH        = 2;
  localparam int NEURON_WIDTH    = 5;
  localparam int INPUT_WIDTH     = 10;
  localparam int IN_COUNT_WIDTH  = 11;
  localparam int OUT_COUNT_WIDTH = 6;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 11;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_FEED        = 2'd2
  } op_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_IN_COUNT  = 2'd0,
    CFG_OUT_COUNT = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic wr_weight;
    logic wr_bias;
    logic take_x;
    logic mac;
    logic first;
    logic acc_rd;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/dlf_ctrl.sv =====
// controller: item decode, config registers, neuron sweep and result sequencing
`default_nettype none
`include "dense_layer_forward_assert.svh"

module dlf_ctrl #(
  parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
  localparam int KW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dlf_pkg::OP_WIDTH-1:0]          op,
  input  logic [dlf_pkg::NEURON_WIDTH-1:0]      neuron_index,
  input  logic [dlf_pkg::INPUT_WIDTH-1:0]       input_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dlf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [dlf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  dlf_pkg::stat_t                        stat,
  output dlf_pkg::cmd_t                         cmd,
  output logic [KW-1:0]                         k_idx,
  output logic [IW-1:0]                         row_pos
);

  import dlf_pkg::*;

  localparam int NOW = $clog2(MAX_OUTPUTS + 1);
  localparam int NIW = $clog2(MAX_INPUTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_MAC       = 5'b00010,
    ST_DRAIN     = 5'b00100,
    ST_EMIT_RD   = 5'b01000,
    ST_EMIT_WAIT = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [KW-1:0]              k, k_next;
  logic [IW-1:0]              pos, pos_next;
  logic [IW-1:0]              row_p, row_p_next;
  logic                       first, first_next;
  logic                       row_done, row_done_next;
  logic [IN_COUNT_WIDTH-1:0]  in_count, in_count_next;
  logic [OUT_COUNT_WIDTH-1:0] out_count, out_count_next;

  logic [NIW-1:0] n_in;
  logic [NOW-1:0] n_out;
  logic [IW-1:0]  p_eff;
  logic [NIW-1:0] p_inc;
  logic           in_accept;
  logic           cfg_write;
  logic           k_last;
  logic           weight_ok;
  logic           bias_ok;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;
  assign k_idx     = k;
  assign row_pos   = row_p;

  assign n_in = (in_count == '0) ? NIW'(1) :
                (32'(in_count) > 32'(MAX_INPUTS)) ? NIW'(MAX_INPUTS) : NIW'(in_count);
  assign n_out = (out_count == '0) ? NOW'(1) :
                 (32'(out_count) > 32'(MAX_OUTPUTS)) ? NOW'(MAX_OUTPUTS) : NOW'(out_count);

  assign p_eff     = (NIW'(pos) >= n_in) ? '0 : pos;
  assign p_inc     = NIW'(p_eff) + NIW'(1);
  assign k_last    = (NOW'(k) + NOW'(1)) == n_out;
  assign weight_ok = (32'(neuron_index) < 32'(MAX_OUTPUTS)) &&
                     (32'(input_index) < 32'(MAX_INPUTS));
  assign bias_ok   = 32'(neuron_index) < 32'(MAX_OUTPUTS);

  always_comb begin
    state_next     = state;
    k_next         = k;
    pos_next       = pos;
    row_p_next     = row_p;
    first_next     = first;
    row_done_next  = row_done;
    in_count_next  = in_count;
    out_count_next = out_count;
    cmd            = '0;
    cmd.first      = first;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (op)
            OP_LOAD_WEIGHT: cmd.wr_weight = weight_ok;
            OP_LOAD_BIAS:   cmd.wr_bias   = bias_ok;
            OP_FEED: begin
              cmd.take_x    = 1'b1;
              row_p_next    = p_eff;
              first_next    = (p_eff == '0);
              row_done_next = (p_inc >= n_in);
              pos_next      = (p_inc >= n_in) ? '0 : IW'(p_inc);
              k_next        = '0;
              state_next    = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (k_last) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          k_next     = '0;
          state_next = row_done ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = k_last;
          if (k_last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + KW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cfg_write) begin
      case (cfg_index)
        CFG_IN_COUNT: begin
          in_count_next = cfg_data[IN_COUNT_WIDTH-1:0];
          pos_next      = '0;
        end
        CFG_OUT_COUNT: begin
          out_count_next = cfg_data[OUT_COUNT_WIDTH-1:0];
          pos_next       = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      pos       <= '0;
      row_p     <= '0;
      first     <= 1'b0;
      row_done  <= 1'b0;
      in_count  <= IN_COUNT_WIDTH'(1);
      out_count <= OUT_COUNT_WIDTH'(1);
    end else begin
      state     <= state_next;
      k         <= k_next;
      pos       <= pos_next;
      row_p     <= row_p_next;
      first     <= first_next;
      row_done  <= row_done_next;
      in_count  <= in_count_next;
      out_count <= out_count_next;
    end
  end

  `DLF_ASSERT_IMPL(a_load_free, clk, rst, cmd.out_load, stat.out_free, "result loaded over a waiting result")
  `DLF_ASSERT_NEXT(a_feed_start, clk, rst, in_accept && op == OP_FEED, state == ST_MAC && k == '0, "feed item did not start the neuron sweep")
  `DLF_ASSERT_IMPL(a_emit_after_drain, clk, rst, state == ST_EMIT_RD && $past(state) == ST_DRAIN, !$past(stat.pipe_busy) && row_done, "results read before the pipeline drained")

endmodule

`default_nettype wire

// ===== src/dlf_datapath.sv =====
// datapath: weight, bias and accumulator memories, multiply-accumulate pipe, result register
`default_nettype none
`include "dense_layer_forward_assert.svh"

module dlf_datapath #(
  parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
  parameter int VALUE_WIDTH = dlf_pkg::VALUE_WIDTH_DEF,
  localparam int KW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dlf_pkg::cmd_t                          cmd,
  output dlf_pkg::stat_t                         stat,
  input  logic [KW-1:0]                          k_idx,
  input  logic [IW-1:0]                          row_pos,
  input  logic [dlf_pkg::NEURON_WIDTH-1:0]       neuron_index,
  input  logic [dlf_pkg::INPUT_WIDTH-1:0]        input_index,
  input  logic signed [VALUE_WIDTH-1:0]          value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dlf_pkg::ACC_WIDTH-1:0]   neuron_value,
  output logic [dlf_pkg::NEURON_WIDTH-1:0]       out_index,
  output logic                                   row_last
);

  import dlf_pkg::*;

  localparam int WDEPTH = 2 ** (KW + IW);
  localparam int BDEPTH = 2 ** KW;
  localparam int PW     = 2 * VALUE_WIDTH;
  localparam int SW     = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0] weight_mem [WDEPTH];
  logic [VALUE_WIDTH-1:0] bias_mem   [BDEPTH];
  logic [ACC_WIDTH-1:0]   acc_mem    [BDEPTH];

  logic signed [VALUE_WIDTH-1:0] w_rd;
  logic signed [VALUE_WIDTH-1:0] b_rd;
  logic signed [ACC_WIDTH-1:0]   acc_rd;
  logic signed [VALUE_WIDTH-1:0] x_reg;

  logic                          s1_valid;
  logic [KW-1:0]                 s1_k;
  logic                          s1_first;

  logic                          s2_valid;
  logic [KW-1:0]                 s2_k;
  logic                          s2_first;
  logic signed [PW-1:0]          prod;
  logic signed [ACC_WIDTH-1:0]   s2_acc;
  logic signed [VALUE_WIDTH-1:0] s2_bias;

  logic signed [SW-1:0]          base;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          clamped;
  logic [KW+IW-1:0]              w_wr_addr;

  assign w_wr_addr = {KW'(neuron_index), IW'(input_index)};

  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      weight_mem[w_wr_addr] <= value;
    end
    if (cmd.mac) begin
      w_rd <= weight_mem[{k_idx, row_pos}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) begin
      bias_mem[KW'(neuron_index)] <= value;
    end
    if (cmd.mac) begin
      b_rd <= bias_mem[k_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc_mem[s2_k] <= ACC_WIDTH'(clamped);
    end
    if (cmd.mac || cmd.acc_rd) begin
      acc_rd <= acc_mem[k_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_x) begin
      x_reg <= value;
    end
    s1_k     <= k_idx;
    s1_first <= cmd.first;
    prod     <= w_rd * x_reg;
    s2_k     <= s1_k;
    s2_first <= s1_first;
    s2_acc   <= acc_rd;
    s2_bias  <= b_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac;
      s2_valid <= s1_valid;
    end
  end

  assign base    = s2_first ? (SW'(s2_bias) <<< FRAC_SHIFT) : SW'(s2_acc);
  assign sum     = base + SW'(prod);
  assign clamped = (sum > SAT_HI) ? SAT_HI : (sum < SAT_LO) ? SAT_LO : sum;

  assign stat.pipe_busy = s1_valid || s2_valid;
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      neuron_value <= acc_rd;
      out_index    <= NEURON_WIDTH'(k_idx);
      row_last     <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `DLF_ASSERT_IMPL(a_s2_follows, clk, rst, s2_valid, $past(s1_valid), "accumulator write without a multiply stage")
  `DLF_ASSERT_IMPL(a_no_emit_in_mac, clk, rst, cmd.out_load || cmd.acc_rd, !s1_valid && !s2_valid, "result read while accumulators update")
  `DLF_ASSERT_IMPL(a_distinct_k, clk, rst, s1_valid && s2_valid, s1_k != s2_k, "two pipeline stages on one neuron")

endmodule

`default_nettype wire

// ===== src/dense_layer_forward.sv =====
// Fully connected layer: a weight or bias load item is written at once.
// A feed item holds in_stall high until done: one shared multiply-accumulate visits each
// active neuron, one per cycle, through a three-stage memory read, multiply, add pipe.
// After the last element of a row, results leave one per accumulator read, held by out_stall.
// Synchronous active-high reset clears control state and sets both counts to 1;
// weight, bias and accumulator memories are not cleared and need no clearing pass.
`default_nettype none

module dense_layer_forward #(
  parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
  parameter int VALUE_WIDTH = dlf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dlf_pkg::OP_WIDTH-1:0]          op,
  input  logic [dlf_pkg::NEURON_WIDTH-1:0]      neuron_index,
  input  logic [dlf_pkg::INPUT_WIDTH-1:0]       input_index,
  input  logic signed [VALUE_WIDTH-1:0]         value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dlf_pkg::ACC_WIDTH-1:0]  neuron_value,
  output logic [dlf_pkg::NEURON_WIDTH-1:0]      out_index,
  output logic                                  row_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dlf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [dlf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  import dlf_pkg::*;

  localparam int KW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [KW-1:0] k_idx;
  logic [IW-1:0] row_pos;

  dlf_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .neuron_index (neuron_index),
    .input_index  (input_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .cmd          (cmd),
    .k_idx        (k_idx),
    .row_pos      (row_pos)
  );

  dlf_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .k_idx        (k_idx),
    .row_pos      (row_pos),
    .neuron_index (neuron_index),
    .input_index  (input_index),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .neuron_value (neuron_value),
    .out_index    (out_index),
    .row_last     (row_last)
  );

endmodule

`default_nettype wire

// ===== dv/dense_layer_checker.sv =====
`timescale 1ns / 100ps
// dense_layer_forward checker: mirrors the stores, predicts neuron results, compares them
module dense_layer_checker (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  logic                                       in_stall,
  input  logic [dlf_pkg::OP_WIDTH-1:0]               op,
  input  logic [dlf_pkg::NEURON_WIDTH-1:0]           neuron_index,
  input  logic [dlf_pkg::INPUT_WIDTH-1:0]            input_index,
  input  logic signed [dlf_pkg::VALUE_WIDTH_DEF-1:0] value,
  input  logic                                       out_valid,
  input  logic                                       out_stall,
  input  logic signed [dlf_pkg::ACC_WIDTH-1:0]       neuron_value,
  input  logic [dlf_pkg::NEURON_WIDTH-1:0]           out_index,
  input  logic                                       row_last,
  input  logic                                       cfg_valid,
  input  logic                                       cfg_ready,
  input  logic [dlf_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [dlf_pkg::CFG_DATA_WIDTH-1:0]         cfg_data,
  output int                                         failures,
  output int                                         results_pending
);

  import dlf_pkg::*;

  localparam int     WEIGHT_DEPTH = MAX_OUTPUTS_DEF * MAX_INPUTS_DEF;
  localparam longint ACC_MAX      = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_MIN      = -ACC_MAX - 1;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] neuron_value;
    logic [NEURON_WIDTH-1:0]     out_index;
    logic                        row_last;
  } neuron_result_t;

  logic signed [VALUE_WIDTH_DEF-1:0] weight_mem [0:WEIGHT_DEPTH-1];
  logic signed [VALUE_WIDTH_DEF-1:0] bias_mem [0:MAX_OUTPUTS_DEF-1];
  logic signed [ACC_WIDTH-1:0]       acc_mem [0:MAX_OUTPUTS_DEF-1];
  neuron_result_t                    neuron_results_due [$];
  neuron_result_t                    due;
  int unsigned                       in_cnt;
  int unsigned                       out_cnt;
  int unsigned                       row_pos;

  task automatic accumulate_element(input logic signed [VALUE_WIDTH_DEF-1:0] x);
    int unsigned n_in;
    int unsigned n_out;
    int unsigned p;
    int unsigned k;
    longint sum;
    neuron_result_t r;
    n_in  = (in_cnt == 0) ? 1 : ((in_cnt > MAX_INPUTS_DEF) ? MAX_INPUTS_DEF : in_cnt);
    n_out = (out_cnt == 0) ? 1 : ((out_cnt > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF : out_cnt);
    p = (row_pos >= n_in) ? 0 : row_pos;
    for (k = 0; k < n_out; k++) begin
      if (p == 0)
        sum = longint'(bias_mem[k]) * (longint'(1) <<< FRAC_SHIFT);
      else
        sum = acc_mem[k];
      sum += longint'(weight_mem[k * MAX_INPUTS_DEF + p]) * longint'(x);
      if (sum > ACC_MAX)
        sum = ACC_MAX;
      else if (sum < ACC_MIN)
        sum = ACC_MIN;
      acc_mem[k] = sum[ACC_WIDTH-1:0];
    end
    row_pos = p + 1;
    if (row_pos >= n_in) begin
      row_pos = 0;
      for (k = 0; k < n_out; k++) begin
        r.neuron_value = acc_mem[k];
        r.out_index    = k[NEURON_WIDTH-1:0];
        r.row_last     = (k + 1 == n_out);
        neuron_results_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_cnt   = 1;
      out_cnt  = 1;
      row_pos  = 0;
      failures = 0;
      neuron_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IN_COUNT: begin
            in_cnt  = cfg_data;
            row_pos = 0;
          end
          CFG_OUT_COUNT: begin
            out_cnt = cfg_data[OUT_COUNT_WIDTH-1:0];
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (op)
          OP_LOAD_WEIGHT: weight_mem[{neuron_index, input_index}] = value;
          OP_LOAD_BIAS:   bias_mem[neuron_index] = value;
          OP_FEED:        accumulate_element(value);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (neuron_results_due.size() == 0) begin
          $display("%0t: unexpected result item, out_index %0d neuron_value %0d",
                   $time, out_index, neuron_value);
          failures++;
        end else begin
          due = neuron_results_due.pop_front();
          if (neuron_value !== due.neuron_value) begin
            $display("%0t: neuron_value expected %0d got %0d",
                     $time, due.neuron_value, neuron_value);
            failures++;
          end
          if (out_index !== due.out_index) begin
            $display("%0t: out_index expected %0d got %0d", $time, due.out_index, out_index);
            failures++;
          end
          if (row_last !== due.row_last) begin
            $display("%0t: row_last expected %0d got %0d", $time, due.row_last, row_last);
            failures++;
          end
        end
      end
    end
    results_pending = neuron_results_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// dense_layer_forward testbench top: clock, reset, stimulus, idling and verdict
module testbench;
  import dlf_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 200;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [OP_WIDTH-1:0]               op = OP_LOAD_WEIGHT;
  logic [NEURON_WIDTH-1:0]           neuron_index = '0;
  logic [INPUT_WIDTH-1:0]            input_index = '0;
  logic signed [VALUE_WIDTH_DEF-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [ACC_WIDTH-1:0]       neuron_value;
  logic [NEURON_WIDTH-1:0]           out_index;
  logic                              row_last;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index = CFG_IN_COUNT;
  logic [CFG_DATA_WIDTH-1:0]         cfg_data = '0;

  int          failures;
  int          results_pending;
  bit          weight_set [0:MAX_OUTPUTS_DEF*MAX_INPUTS_DEF-1];
  bit          bias_set [0:MAX_OUTPUTS_DEF-1];
  int unsigned eff_in = 1;
  int unsigned eff_out = 1;
  int unsigned items_sent = 0;
  int unsigned quiet = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  dense_layer_forward dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .neuron_index(neuron_index), .input_index(input_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .neuron_value(neuron_value), .out_index(out_index), .row_last(row_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dense_layer_checker results_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .neuron_index(neuron_index), .input_index(input_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .neuron_value(neuron_value), .out_index(out_index), .row_last(row_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .results_pending(results_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [VALUE_WIDTH_DEF-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_item(input logic [OP_WIDTH-1:0] kind, input logic [NEURON_WIDTH-1:0] n,
                          input logic [INPUT_WIDTH-1:0] pos,
                          input logic signed [VALUE_WIDTH_DEF-1:0] v);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    neuron_index <= n;
    input_index  <= pos;
    value        <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == OP_LOAD_WEIGHT) weight_set[{n, pos}] = 1'b1;
    if (kind == OP_LOAD_BIAS) bias_set[n] = 1'b1;
    if (kind != OP_UNUSED) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IN_COUNT)
      eff_in = (data == 0) ? 1 : ((data > MAX_INPUTS_DEF) ? MAX_INPUTS_DEF : data);
    else
      eff_out = (data[OUT_COUNT_WIDTH-1:0] == 0) ? 1 :
                ((data[OUT_COUNT_WIDTH-1:0] > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF :
                 data[OUT_COUNT_WIDTH-1:0]);
  endtask

  // every weight and bias the active rows read gets written first
  task automatic fill_stores();
    int unsigned k;
    int unsigned p;
    for (k = 0; k < eff_out; k++) begin
      if (!bias_set[k]) put_item(OP_LOAD_BIAS, k, $urandom, rand_value());
      for (p = 0; p < eff_in; p++)
        if (!weight_set[k * MAX_INPUTS_DEF + p]) put_item(OP_LOAD_WEIGHT, k, p, rand_value());
    end
  endtask

  task automatic run_rows(input int unsigned rows);
    int unsigned r;
    int unsigned p;
    for (r = 0; r < rows; r++) begin
      for (p = 0; p < eff_in; p++) begin
        case ($urandom_range(0, 17))
          0: put_item(OP_UNUSED, $urandom, $urandom, $urandom);
          1: put_item(OP_LOAD_WEIGHT, $urandom, $urandom, rand_value());
          2: put_item(OP_LOAD_BIAS, $urandom, $urandom, rand_value());
          default: ;
        endcase
        put_item(OP_FEED, $urandom, $urandom, rand_value());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset counts: one element per row, one neuron
    put_item(OP_LOAD_BIAS, 0, 0, 16'sh7FFF);
    put_item(OP_LOAD_WEIGHT, 0, 0, 16'sh7FFF);
    put_item(OP_FEED, 0, 0, 16'sh7FFF);
    put_item(OP_FEED, 0, 0, 16'sh8000);
    put_item(OP_LOAD_WEIGHT, 0, 0, 16'sh8000);
    put_item(OP_FEED, 0, 0, 16'sh8000);
    put_item(OP_LOAD_BIAS, 0, 0, 16'sh8000);
    put_item(OP_FEED, 31, 1023, 16'sh7FFF);
    put_item(OP_FEED, 0, 0, 16'sh0000);
    put_item(OP_UNUSED, 31, 1023, 16'shFFFF);
    put_item(OP_LOAD_WEIGHT, 31, 1023, 16'sh8000);
    put_item(OP_LOAD_BIAS, 31, 1023, 16'sh7FFF);
    put_item(OP_FEED, 0, 0, 16'sh4001);

    // a register write drops a partly fed row
    set_reg(CFG_IN_COUNT, 3);
    set_reg(CFG_OUT_COUNT, 2);
    fill_stores();
    put_item(OP_FEED, 0, 0, rand_value());
    put_item(OP_FEED, 0, 0, rand_value());
    // zero counts act as one
    set_reg(CFG_IN_COUNT, 0);
    set_reg(CFG_OUT_COUNT, 0);
    fill_stores();
    run_rows(2);
    // output count above the maximum, then exactly the maximum
    set_reg(CFG_IN_COUNT, 2);
    set_reg(CFG_OUT_COUNT, 63);
    fill_stores();
    run_rows(2);
    set_reg(CFG_OUT_COUNT, MAX_OUTPUTS_DEF);
    run_rows(1);

    while (items_sent < RANDOM_ITEMS) begin
      set_reg(CFG_IN_COUNT, $urandom_range(1, 6));
      set_reg(CFG_OUT_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) :
                                                           $urandom_range(1, 8));
      fill_stores();
      run_rows($urandom_range(1, 4));
      if (eff_in > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, eff_in - 1)) put_item(OP_FEED, $urandom, $urandom, rand_value());
    end

    drain();
    if (failures == 0)
      $display("dense_layer_forward regression: pass");
    else
      $display("dense_layer_forward regression: fail");
    $finish;
  end

  initial begin
    int unsigned hold;
    forever begin
      if ($urandom_range(0, 23) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("dense_layer_forward regression: fail");
    $finish;
  end

endmodule

// ===== dense_layer_forward.f =====
+incdir+src
src/dlf_pkg.sv
src/dlf_ctrl.sv
src/dlf_datapath.sv
src/dense_layer_forward.sv
dv/dense_layer_checker.sv
dv/testbench.sv
